>>> hdl/gamepad_report_decoder_assert.svh
// ----------------------------------------------------------------------------
// Gamepad report decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_DECODER_ASSERT_SVH
`define GAMEPAD_REPORT_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gprd_pkg.sv
// ----------------------------------------------------------------------------
// gprd_pkg
// Types and constants shared by the gamepad report decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gprd_pkg;

  localparam int unsigned PadSlotsDefault = 4;
  localparam int unsigned ReportBlocks    = 4;
  localparam int unsigned BlockLen        = 9;
  localparam logic [7:0]  HeaderMark      = 8'h21;
  localparam logic [7:0]  ThresholdReset  = 8'd170;
  // 1500 ticks per second times 243000/4 polls.
  localparam logic [31:0] TimeoutReset    = 32'd91125000;

  typedef enum logic [1:0] {
    KindByte    = 2'd0,
    KindTick    = 2'd1,
    KindLinkErr = 2'd2
  } kind_e;

  typedef enum logic {
    CfgThreshold = 1'b0,
    CfgTimeout   = 1'b1
  } cfg_idx_e;

  // Six origin bytes: main x/y, aux x/y, left trigger, right trigger.
  typedef logic [5:0][7:0] origin_t;

  // Control from the decode pipeline to the origin store.
  typedef struct packed {
    logic rd_en;     // read origin of rd_slot
    logic wr_en;     // write origin of wr_slot
    logic set_valid; // mark wr_slot origin captured
    logic clr_valid; // drop wr_slot origin
    logic clr_all;   // drop every origin
  } org_ctl_t;

endpackage

`default_nettype wire

>>> hdl/gprd_origin_store.sv
// ----------------------------------------------------------------------------
// gprd_origin_store
// Per-slot origin memory with a registered read port and captured flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gprd_origin_store
  import gprd_pkg::*;
#(
  parameter int unsigned PadSlots = PadSlotsDefault,
  parameter int unsigned SlotW    = (PadSlots > 1) ? $clog2(PadSlots) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire org_ctl_t            ctl_i,
  input  wire logic [SlotW-1:0]    rd_slot_i,
  input  wire logic [SlotW-1:0]    wr_slot_i,
  input  wire origin_t             wr_data_i,
  output origin_t                  rd_data_o,
  output logic      [PadSlots-1:0] valid_o
);

  origin_t               mem_q [PadSlots];
  origin_t               rd_q;
  logic   [PadSlots-1:0] valid_q;
  logic   [PadSlots-1:0] valid_d;

  // Forward a write into a read of the same slot.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_slot_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= (ctl_i.wr_en && (wr_slot_i == rd_slot_i)) ? wr_data_i : mem_q[rd_slot_i];
    end
  end

  // Clear-all wins over a per-slot update in the same cycle.
  always_comb begin
    valid_d = valid_q;
    if (ctl_i.set_valid) begin
      valid_d[wr_slot_i] = 1'b1;
    end
    if (ctl_i.clr_valid) begin
      valid_d[wr_slot_i] = 1'b0;
    end
    if (ctl_i.clr_all) begin
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rd_data_o = rd_q;
  assign valid_o   = valid_q;

endmodule

`default_nettype wire

>>> hdl/gamepad_report_decoder.sv
// ----------------------------------------------------------------------------
// gamepad_report_decoder
// Decodes 37-byte adapter reports into one result per controller slot.
// ----------------------------------------------------------------------------
// The block takes one request per cycle on the slave stream: a report byte,
// a time tick or a link error, selected by tuser. A report opens on a byte
// flagged start-of-report; if that header byte is not 0x21 the rest of the
// report is swallowed. Of the four 9-byte controller blocks, each of an active
// slot gives one result on its ninth byte: that byte is accepted with the
// slot's origin read, the origin memory answers as the block enters the
// decode stage and the result moves into the output register once it is free,
// so report bytes flow at one per cycle as long as the master side takes
// results. A link error, or a tick that pushes the idle counter past
// timeout_ticks, reports each of the min(PAD_SLOTS, 4) active slots
// disconnected and takes no new request until the last one has entered the
// decode stage. The origin memory needs no clearing pass after reset;
// per-slot captured flags in flip-flops mark which entries hold an origin.
// Configuration is written through the cfg port, which is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gamepad_report_decoder_assert.svh"

module gamepad_report_decoder
  import gprd_pkg::*;
#(
  parameter int unsigned PAD_SLOTS = PadSlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] report_byte
  input  wire logic [2:0]  s_axis_tuser,  // [1:0] kind, [2] start_of_report
  // Master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] pad_index, [2] connected, [14:3] buttons, [22:15] main_stick_x,
  // [30:23] main_stick_y, [38:31] aux_stick_x, [46:39] aux_stick_y,
  // [54:47] left_slider, [62:55] right_slider, [63] zero
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast,  // last_of_run
  // Configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned SlotW       = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1;
  localparam int unsigned ActiveSlots = (PAD_SLOTS < ReportBlocks) ? PAD_SLOTS : ReportBlocks;
  localparam logic [3:0]  LastOffset  = 4'(BlockLen - 1);
  localparam logic [1:0]  LastBlock   = 2'(ReportBlocks - 1);

  // Configuration
  logic [7:0]  thr_q;
  logic [31:0] timeout_q;

  // Report tracking
  logic        open_q, open_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [3:0]  off_q, off_d;
  logic [1:0]  blk_q, blk_d;
  logic [7:0]  blk_bytes_q [8];
  logic        bytes_we;

  // Idle timeout
  logic [31:0] idle_q, idle_d, idle_inc;
  logic        to_rep_q, to_rep_d;
  logic        tick_fire;

  // Disconnect burst
  logic        burst_q, burst_d;
  logic [1:0]  burst_slot_q, burst_slot_d;
  logic        burst_last;

  // Decode stage
  logic        s1_valid_q, s1_valid_d;
  logic        s1_dec_q, s1_dec_d;
  logic        s1_ok_q, s1_ok_d;
  logic [1:0]  s1_slot_q, s1_slot_d;
  logic        s1_last_q, s1_last_d;
  logic [11:0] s1_btn_q, s1_btn_d;
  origin_t     s1_raw_q, s1_raw_d;
  logic        s1_load_dec;
  logic        s1_load_burst;

  // Output register
  logic        m_valid_q;
  logic [63:0] m_data_q;
  logic        m_last_q;
  logic [63:0] res_data;

  // Handshake and datapath
  kind_e       kind;
  logic        sor;
  logic [7:0]  rbyte;
  logic        in_acc;
  logic        out_free;
  logic        advance;
  logic        dec_hit;
  logic        trig_burst;

  org_ctl_t              org_ctl;
  logic [SlotW-1:0]      org_rd_slot;
  logic [SlotW-1:0]      org_wr_slot;
  origin_t               org_rd_data;
  logic [PAD_SLOTS-1:0]  org_valid;
  origin_t               org_use;
  logic [5:0][7:0]       diff;
  logic [5:0][7:0]       res_axis;
  logic                  res_conn;

  assign kind  = kind_e'(s_axis_tuser[1:0]);
  assign sor   = s_axis_tuser[2];
  assign rbyte = s_axis_tdata;

  // Output register frees when empty or drained; the decode stage follows.
  assign out_free      = !m_valid_q || m_axis_tready;
  assign advance       = s1_valid_q && out_free;
  assign s_axis_tready = (!s1_valid_q || out_free) && !burst_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Configuration: always ready; user lands writes with block idle, unchecked.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ThresholdReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgThreshold: thr_q     <= cfg_data_i[7:0];
        CfgTimeout:   timeout_q <= cfg_data_i;
        default:      thr_q     <= thr_q;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request decode: byte position, timeout counter, burst start.
  // --------------------------------------------------------------------------
  // Saturating idle count; the timeout fires once per quiet spell.
  assign idle_inc  = (idle_q == '1) ? idle_q : idle_q + 32'd1;
  assign tick_fire = (idle_inc > timeout_q) && !to_rep_q;

  // Ninth byte of a block inside a good report for an active slot.
  assign dec_hit = open_q && hdr_ok_q && (off_q == LastOffset)
                   && ({1'b0, blk_q} < 3'(ActiveSlots));

  always_comb begin
    open_d      = open_q;
    hdr_ok_d    = hdr_ok_q;
    off_d       = off_q;
    blk_d       = blk_q;
    idle_d      = idle_q;
    to_rep_d    = to_rep_q;
    bytes_we    = 1'b0;
    trig_burst  = 1'b0;
    s1_load_dec = 1'b0;
    if (in_acc) begin
      case (kind)
        KindByte: begin
          if (sor) begin
            // Open a new report, abandoning any partial one.
            open_d   = 1'b1;
            hdr_ok_d = (rbyte == HeaderMark);
            off_d    = '0;
            blk_d    = '0;
          end else if (open_q) begin
            bytes_we    = (off_q != LastOffset);
            s1_load_dec = dec_hit;
            if (off_q == LastOffset) begin
              off_d = '0;
              blk_d = blk_q + 2'd1;
              if (blk_q == LastBlock) begin
                // Close the report; a good one restarts the idle timer.
                open_d = 1'b0;
                if (hdr_ok_q) begin
                  idle_d   = '0;
                  to_rep_d = 1'b0;
                end
              end
            end else begin
              off_d = off_q + 4'd1;
            end
          end
        end
        KindTick: begin
          idle_d = idle_inc;
          if (tick_fire) begin
            to_rep_d   = 1'b1;
            trig_burst = 1'b1;
          end
        end
        KindLinkErr: begin
          trig_burst = 1'b1;
        end
        default: begin
          // Drop unknown kinds.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      hdr_ok_q <= 1'b0;
      off_q    <= '0;
      blk_q    <= '0;
      idle_q   <= '0;
      to_rep_q <= 1'b0;
    end else begin
      open_q   <= open_d;
      hdr_ok_q <= hdr_ok_d;
      off_q    <= off_d;
      blk_q    <= blk_d;
      idle_q   <= idle_d;
      to_rep_q <= to_rep_d;
    end
  end

  // Block bytes hold payload only; each is written before its block decodes.
  always_ff @(posedge clk_i) begin
    if (bytes_we) begin
      blk_bytes_q[off_q[2:0]] <= rbyte;
    end
  end

  // --------------------------------------------------------------------------
  // Disconnect burst: one disconnected result per active slot.
  // --------------------------------------------------------------------------
  assign burst_last    = ({1'b0, burst_slot_q} == 3'(ActiveSlots - 1));
  assign s1_load_burst = burst_q && (!s1_valid_q || out_free);

  always_comb begin
    burst_d      = burst_q;
    burst_slot_d = burst_slot_q;
    if (trig_burst) begin
      burst_d      = 1'b1;
      burst_slot_d = '0;
    end else if (s1_load_burst) begin
      burst_d      = !burst_last;
      burst_slot_d = burst_slot_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q      <= 1'b0;
      burst_slot_q <= '0;
    end else begin
      burst_q      <= burst_d;
      burst_slot_q <= burst_slot_d;
    end
  end

  // --------------------------------------------------------------------------
  // Decode stage: hold the block while the origin memory answers.
  // --------------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_dec_d   = s1_dec_q;
    s1_ok_d    = s1_ok_q;
    s1_slot_d  = s1_slot_q;
    s1_last_d  = s1_last_q;
    s1_btn_d   = s1_btn_q;
    s1_raw_d   = s1_raw_q;
    if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (s1_load_dec) begin
      s1_valid_d = 1'b1;
      s1_dec_d   = 1'b1;
      s1_ok_d    = (blk_bytes_q[0][7:4] inside {4'd1, 4'd2});
      s1_slot_d  = blk_q;
      s1_last_d  = 1'b1;
      s1_btn_d   = {(rbyte >= thr_q), (blk_bytes_q[7] >= thr_q),
                    blk_bytes_q[2][1:0], blk_bytes_q[1]};
      s1_raw_d   = {rbyte, blk_bytes_q[7], blk_bytes_q[6], blk_bytes_q[5],
                    blk_bytes_q[4], blk_bytes_q[3]};
    end else if (s1_load_burst) begin
      s1_valid_d = 1'b1;
      s1_dec_d   = 1'b0;
      s1_ok_d    = 1'b0;
      s1_slot_d  = burst_slot_q;
      s1_last_d  = burst_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_dec_q   <= 1'b0;
      s1_ok_q    <= 1'b0;
      s1_slot_q  <= '0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_dec_q   <= s1_dec_d;
      s1_ok_q    <= s1_ok_d;
      s1_slot_q  <= s1_slot_d;
      s1_last_q  <= s1_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_btn_q <= s1_btn_d;
    s1_raw_q <= s1_raw_d;
  end

  // --------------------------------------------------------------------------
  // Origin store: read on the ninth byte, write back when the result leaves.
  // --------------------------------------------------------------------------
  assign org_rd_slot = SlotW'(blk_q);
  assign org_wr_slot = SlotW'(s1_slot_q);

  always_comb begin
    org_ctl           = '0;
    org_ctl.rd_en     = s1_load_dec;
    org_ctl.clr_all   = trig_burst;
    if (advance && s1_dec_q) begin
      // Capture the origin on the first good block after a disconnect.
      org_ctl.set_valid = s1_ok_q;
      org_ctl.wr_en     = s1_ok_q && !org_valid[org_wr_slot];
      org_ctl.clr_valid = !s1_ok_q;
    end
  end

  gprd_origin_store #(
    .PadSlots (PAD_SLOTS),
    .SlotW    (SlotW)
  ) u_origin (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (org_ctl),
    .rd_slot_i (org_rd_slot),
    .wr_slot_i (org_wr_slot),
    .wr_data_i (s1_raw_q),
    .rd_data_o (org_rd_data),
    .valid_o   (org_valid)
  );

  // --------------------------------------------------------------------------
  // Result: sticks wrap, sliders clamp at zero, disconnected zero except slot.
  // --------------------------------------------------------------------------
  assign org_use  = org_valid[org_wr_slot] ? org_rd_data : s1_raw_q;
  assign res_conn = s1_dec_q && s1_ok_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      diff[i] = s1_raw_q[i] - org_use[i];
    end
    for (int i = 0; i < 4; i++) begin
      res_axis[i] = diff[i];
    end
    for (int i = 4; i < 6; i++) begin
      res_axis[i] = (s1_raw_q[i] < org_use[i]) ? 8'd0 : diff[i];
    end
    if (res_conn) begin
      res_data = {1'b0, res_axis[5], res_axis[4], res_axis[3], res_axis[2],
                  res_axis[1], res_axis[0], s1_btn_q, 1'b1, s1_slot_q};
    end else begin
      res_data = {61'd0, 1'b0, s1_slot_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_data_q <= res_data;
      m_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `GPRD_ASSERT_NOW(a_burst_blocks_input, burst_q, !s_axis_tready,
                   "request taken during disconnect burst")
  `GPRD_ASSERT_NEXT(a_stage_holds, s1_valid_q && !out_free,
                    s1_valid_q && $stable(s1_slot_q) && $stable(s1_dec_q),
                    "decode stage lost its block under stall")
  `GPRD_ASSERT_NOW(a_disc_zero, m_axis_tvalid && !m_axis_tdata[2],
                   m_axis_tdata[63:3] == '0,
                   "disconnected result carries data")
  `GPRD_ASSERT_NOW(a_capture_once, org_ctl.wr_en, !org_valid[org_wr_slot],
                   "origin overwritten while captured")

endmodule

`default_nettype wire
